>>> hdl/lpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern pixel package
// Widths, codes and shared types of the pattern pixel unit.
// ----------------------------------------------------------------------------
package lpp_pkg;

   localparam int IDX_W       = 10;
   localparam int LEN_W       = 11;
   localparam int MODE_W      = 3;
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int NUM_W       = 19;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RUNNER   = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_MODE = 3'd0,
      CSR_FIRST_COLOR  = 3'd1,
      CSR_SECOND_COLOR = 3'd2,
      CSR_STRIP_LENGTH = 3'd3,
      CSR_BLANK_OFFSET = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_BLACK,
      KIND_FILL,
      KIND_GRADIENT
   } kind_type;

   typedef struct packed {
      logic [MODE_W-1:0]  pattern_mode;
      logic [COLOR_W-1:0] first_color;
      logic [COLOR_W-1:0] second_color;
      logic [LEN_W-1:0]   strip_length;
      logic [LEN_W-1:0]   blank_offset;
   } cfg_type;

   typedef struct packed {
      kind_type                          kind;
      logic [LEN_W-1:0]                  divisor;
      logic [NUM_CHAN-1:0][NUM_W-1:0]    rem;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]   quot;
   } div_word_type;

endpackage

>>> hdl/lpp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern pixel channels
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface lpp_req_if import lpp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] pixel_index;
   logic [IDX_W-1:0] runner_start;

   modport source (output valid, output pixel_index, output runner_start, input ready);
   modport sink   (input valid, input pixel_index, input runner_start, output ready);
endinterface

interface lpp_rsp_if import lpp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lpp_csr_if import lpp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/lpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern pixel front end
// Range checks, runner decision and gradient numerators in two stages.
// ----------------------------------------------------------------------------
module lpp_front import lpp_pkg::*; #(
   parameter int MAX_PIXELS     = 1024,
   parameter int RUNNER_DIVISOR = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [IDX_W-1:0]   pixel_index,
   input  logic [IDX_W-1:0]   runner_start,
   output logic               out_valid,
   input  logic               out_ready,
   output div_word_type       out_word
);

   localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
   localparam int unsigned LEN_CAP = (MAX_PIXELS > LEN_MAX) ? LEN_MAX : MAX_PIXELS;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_CAP);
   localparam int RUN_SHIFT = LEN_W + $clog2(RUNNER_DIVISOR);
   localparam int RECIP_W   = LEN_W + 2;
   localparam int RUN_RECIP = ((1 << RUN_SHIFT) + RUNNER_DIVISOR - 1) / RUNNER_DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RUN_RECIP);
   localparam int PROD_W    = LEN_W + RECIP_W;

   logic             s1_load;
   logic             s2_load;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] idx_ext;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_range_ff, s1_range_in;
   logic [LEN_W-1:0] s1_span_ff,  s1_span_in;
   logic [LEN_W-1:0] s1_rest_ff,  s1_rest_in;
   logic [IDX_W-1:0] s1_pos_ff,   s1_pos_in;
   logic [IDX_W-1:0] s1_start_ff;

   logic [PROD_W-1:0] seg_prod;
   logic [LEN_W-1:0]  seg;
   logic              lit;
   logic              s2_valid_ff, s2_valid_in;
   div_word_type      s2_word_ff,  s2_word_in;

   assign s2_load  = !s2_valid_ff || out_ready;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;

   always_comb begin
      len         = (cfg.strip_length > LEN_LIMIT) ? LEN_LIMIT : cfg.strip_length;
      idx_ext     = {1'b0, pixel_index};
      s1_range_in = (idx_ext < len) && (idx_ext >= cfg.blank_offset);
      s1_span_in  = len - cfg.blank_offset;
      s1_rest_in  = len - idx_ext;
      s1_pos_in   = IDX_W'(idx_ext - cfg.blank_offset);
      s1_valid_in = s1_load ? in_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && in_valid) begin
         s1_range_ff <= s1_range_in;
         s1_span_ff  <= s1_span_in;
         s1_rest_ff  <= s1_rest_in;
         s1_pos_ff   <= s1_pos_in;
         s1_start_ff <= runner_start;
      end
   end

   always_comb begin
      seg_prod = PROD_W'(s1_span_ff) * PROD_W'(RECIP);
      seg      = LEN_W'(seg_prod >> RUN_SHIFT);
      lit      = (s1_pos_ff >= s1_start_ff) &&
                 (LEN_W'(s1_pos_ff - s1_start_ff) < seg);

      s2_word_in.divisor = s1_span_ff;
      s2_word_in.quot    = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s2_word_in.rem[c] =
            NUM_W'(cfg.first_color[COLOR_W-1-CHAN_W*c -: CHAN_W]) * NUM_W'(s1_rest_ff) +
            NUM_W'(cfg.second_color[COLOR_W-1-CHAN_W*c -: CHAN_W]) * NUM_W'(s1_pos_ff);
      end

      if (!s1_range_ff) begin
         s2_word_in.kind = KIND_BLACK;
      end else begin
         unique case (cfg.pattern_mode)
            MODE_GRADIENT: s2_word_in.kind = KIND_GRADIENT;
            MODE_RUNNER:   s2_word_in.kind = lit ? KIND_FILL : KIND_BLACK;
            default:       s2_word_in.kind = KIND_FILL;
         endcase
      end

      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         s2_word_ff <= s2_word_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

endmodule

>>> hdl/lpp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern pixel divider cell
// One restoring division step per cell for all three color channels.
// ----------------------------------------------------------------------------
module lpp_div_cell import lpp_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_word_type in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output div_word_type out_word
);

   logic              load;
   logic [NUM_W-1:0]  dsh;
   logic              valid_ff, valid_in;
   div_word_type      word_ff,  word_in;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_comb begin
      word_in = in_word;
      dsh     = NUM_W'(in_word.divisor) << SHIFT;
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (in_word.rem[c] >= dsh) begin
            word_in.rem[c]         = in_word.rem[c] - dsh;
            word_in.quot[c][SHIFT] = 1'b1;
         end
      end
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hdl/led_strip_pattern_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern pixel unit
// Path: front end stages, eight divider cells, then the response register.
// Throughput: one pixel per cycle while rsp_bus.ready is high.
// Each stage moves on as soon as the one after it is free.
// Reset clears every stage valid bit and loads the register reset values.
// ----------------------------------------------------------------------------
module led_strip_pattern_pixel_unit import lpp_pkg::*; #(
   parameter int MAX_PIXELS     = 1024,
   parameter int RUNNER_DIVISOR = 15
) (
   input  logic   clock,
   input  logic   reset,
   lpp_req_if.sink   req_bus,
   lpp_rsp_if.source rsp_bus,
   lpp_csr_if.sink   csr_bus
);

   cfg_type cfg_ff, cfg_in;

   logic [CHAN_W:0] chain_valid;
   logic [CHAN_W:0] chain_ready;
   div_word_type    chain_word [CHAN_W+1];

   logic                             out_load;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]  color_ff, color_in;
   div_word_type                     last_word;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PATTERN_MODE: cfg_in.pattern_mode = MODE_W'(csr_bus.data);
            CSR_FIRST_COLOR:  cfg_in.first_color  = COLOR_W'(csr_bus.data);
            CSR_SECOND_COLOR: cfg_in.second_color = COLOR_W'(csr_bus.data);
            CSR_STRIP_LENGTH: cfg_in.strip_length = LEN_W'(csr_bus.data);
            CSR_BLANK_OFFSET: cfg_in.blank_offset = LEN_W'(csr_bus.data);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_mode <= MODE_W'(1);
         cfg_ff.first_color  <= '0;
         cfg_ff.second_color <= '0;
         cfg_ff.strip_length <= '0;
         cfg_ff.blank_offset <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpp_front #(
      .MAX_PIXELS     (MAX_PIXELS),
      .RUNNER_DIVISOR (RUNNER_DIVISOR)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_bus.valid),
      .in_ready     (req_bus.ready),
      .pixel_index  (req_bus.pixel_index),
      .runner_start (req_bus.runner_start),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_word     (chain_word[0])
   );

   for (genvar k = 0; k < CHAN_W; k++) begin : g_cell
      lpp_div_cell #(
         .SHIFT (CHAN_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_word   (chain_word[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_word  (chain_word[k+1])
      );
   end

   assign out_load            = !rsp_valid_ff || rsp_bus.ready;
   assign chain_ready[CHAN_W] = out_load;
   assign last_word           = chain_word[CHAN_W];

   always_comb begin
      rsp_valid_in = out_load ? chain_valid[CHAN_W] : rsp_valid_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         case (last_word.kind)
            KIND_GRADIENT: color_in[c] = last_word.quot[c];
            KIND_FILL:     color_in[c] = cfg_ff.first_color[COLOR_W-1-CHAN_W*c -: CHAN_W];
            default:       color_in[c] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && chain_valid[CHAN_W]) begin
         color_ff <= color_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red   = color_ff[0];
   assign rsp_bus.green = color_ff[1];
   assign rsp_bus.blue  = color_ff[2];

endmodule
